// File: rtl/msg_pkg.sv
// Shared types and constants of the multi-motor step generator.
// Used by msg_motor_lane and multi_stepper_step_generator; depends on nothing.
package msg_pkg;

    // Motor count and field widths
    localparam int NUM_MOTORS = 4;
    localparam int PIN_W      = 4;   // width of each per-motor pin field
    localparam int HP_W       = 16;  // half-period and tick counter width
    localparam int LVL_W      = 4;   // width of the direction level registers
    localparam int MOTOR_W    = 2;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEADY_HP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_LVL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_LVL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_REL  = 3'd5;

    // Reset values of the configuration registers
    localparam logic [HP_W-1:0]  STEADY_HP_RST = 16'd10;
    localparam logic [HP_W-1:0]  START_HP_RST  = 16'd50;
    localparam logic [HP_W-1:0]  RAMP_STEP_RST = 16'd1;
    localparam logic [LVL_W-1:0] FWD_LVL_RST   = 4'hF;
    localparam logic [LVL_W-1:0] REV_LVL_RST   = 4'h0;
    localparam logic             STOP_REL_RST  = 1'b1;

    // Item kind carried in tuser
    localparam logic OPC_TICK = 1'b0;
    localparam logic OPC_CMD  = 1'b1;

    // Command codes; every other nonzero code means reverse
    localparam logic [CMD_W-1:0] CMD_STOP = 2'b00;
    localparam logic [CMD_W-1:0] CMD_FWD  = 2'b01;

    // Direction a motor currently runs in
    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    // Settings shared by all motor lanes
    typedef struct packed {
        logic [HP_W-1:0] steady_hp;
        logic [HP_W-1:0] start_hp;
        logic [HP_W-1:0] ramp_step;
        logic            stop_rel;
    } t_lane_cfg;

    // Pin levels of one motor after the current item
    typedef struct packed {
        logic step;
        logic dir;
        logic enable;
        logic active;
    } t_lane_pins;

endpackage

// File: rtl/multi_stepper_step_generator.sv
// Top level of the multi-motor step-pulse generator with acceleration ramp.
// Depends on msg_pkg and msg_motor_lane.
//
// Usage:
//   Input stream (i_s_*): one item per transfer. tuser is the item kind:
//   a timer tick advances every running motor, a command stops, starts or
//   reverses the motor named in tdata.
//   Output stream (o_m_*): exactly one result per input item, in order,
//   carrying step, direction, enable and running levels of motors 0..3.
//   Config channel (i_cfg_*): register index and data; always ready.
//   Registers are meant to be written only while the block is idle.
// Timing:
//   Each item updates all motor lanes together; its result sits in the
//   output register in the cycle after it is taken. One item per cycle is
//   taken while the output register is empty or being drained.
//   When the receiver stalls, the held result keeps tready low.
// Reset:
//   Synchronous active-low reset clears the output valid flag, stops all
//   motors with drivers disabled and restores the register defaults.
module multi_stepper_step_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [1:0] motor, [3:2] direction_cmd, [7:4] zero
    input  logic [msg_pkg::S_DATA_W-1:0]   i_s_tdata,
    // [0] opcode
    input  logic                           i_s_tuser,
    // output stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [3:0] step_pins, [7:4] dir_pins, [11:8] enable_pins, [15:12] running
    output logic [msg_pkg::M_DATA_W-1:0]   o_m_tdata,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [msg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [msg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import msg_pkg::*;

    logic [HP_W-1:0]  r_steady_hp;
    logic [HP_W-1:0]  r_start_hp;
    logic [HP_W-1:0]  r_ramp_step;
    logic [LVL_W-1:0] r_fwd_lvl;
    logic [LVL_W-1:0] r_rev_lvl;
    logic             r_stop_rel;

    logic                  r_out_valid;
    logic [M_DATA_W-1:0]   r_out_data;
    logic [M_DATA_W-1:0]   n_out_data;

    logic                  w_accept;
    logic                  w_tick;
    logic                  w_is_cmd;
    logic [MOTOR_W-1:0]    w_motor;
    logic [CMD_W-1:0]      w_cmd_code;
    t_lane_cfg             w_cfg;
    t_lane_pins            w_pins [NUM_MOTORS];
    logic [PIN_W-1:0]      w_step;
    logic [PIN_W-1:0]      w_dir;
    logic [PIN_W-1:0]      w_en;
    logic [PIN_W-1:0]      w_run;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steady_hp <= STEADY_HP_RST;
            r_start_hp  <= START_HP_RST;
            r_ramp_step <= RAMP_STEP_RST;
            r_fwd_lvl   <= FWD_LVL_RST;
            r_rev_lvl   <= REV_LVL_RST;
            r_stop_rel  <= STOP_REL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEADY_HP: r_steady_hp <= i_cfg_data;
                CFG_START_HP:  r_start_hp  <= i_cfg_data;
                CFG_RAMP_STEP: r_ramp_step <= i_cfg_data;
                CFG_FWD_LVL:   r_fwd_lvl   <= i_cfg_data[LVL_W-1:0];
                CFG_REV_LVL:   r_rev_lvl   <= i_cfg_data[LVL_W-1:0];
                CFG_STOP_REL:  r_stop_rel  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_cfg.steady_hp = r_steady_hp;
    assign w_cfg.start_hp  = r_start_hp;
    assign w_cfg.ramp_step = r_ramp_step;
    assign w_cfg.stop_rel  = r_stop_rel;

    // Input decode
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_motor    = i_s_tdata[MOTOR_W-1:0];
    assign w_cmd_code = i_s_tdata[MOTOR_W +: CMD_W];
    assign w_tick     = w_accept && (i_s_tuser == OPC_TICK);
    assign w_is_cmd   = w_accept && (i_s_tuser == OPC_CMD);

    // One lane per motor; motors past the level registers get level 0
    for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_lane
        logic w_sel;
        logic w_fwd;
        logic w_rev;

        assign w_sel = w_is_cmd && (int'(w_motor) == m);
        if (m < LVL_W) begin : g_lvl
            assign w_fwd = r_fwd_lvl[m];
            assign w_rev = r_rev_lvl[m];
        end else begin : g_nolvl
            assign w_fwd = 1'b0;
            assign w_rev = 1'b0;
        end

        msg_motor_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tick      (w_tick),
            .i_cmd       (w_sel),
            .i_cmd_code  (w_cmd_code),
            .i_cfg       (w_cfg),
            .i_fwd_level (w_fwd),
            .i_rev_level (w_rev),
            .o_pins      (w_pins[m])
        );
    end

    // Gather the first four motors into the pin fields
    always_comb begin
        w_step = '0;
        w_dir  = '0;
        w_en   = '0;
        w_run  = '0;
        for (int i = 0; i < PIN_W; i++) begin
            if (i < NUM_MOTORS) begin
                w_step[i] = w_pins[i].step;
                w_dir[i]  = w_pins[i].dir;
                w_en[i]   = w_pins[i].enable;
                w_run[i]  = w_pins[i].active;
            end
        end
        n_out_data = {w_run, w_en, w_dir, w_step};
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// File: rtl/msg_motor_lane.sv
// State and update logic of one stepper motor: tick counter, step toggle,
// ramp of the half-period and command handling. Depends on msg_pkg.
module msg_motor_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,      // tick transfer accepted
    input  logic               i_cmd,       // command transfer for this motor
    input  logic [msg_pkg::CMD_W-1:0] i_cmd_code,
    input  msg_pkg::t_lane_cfg i_cfg,
    input  logic               i_fwd_level,
    input  logic               i_rev_level,
    output msg_pkg::t_lane_pins o_pins      // levels after this cycle's item
);
    import msg_pkg::*;

    logic            r_active, n_active;
    logic            r_step,   n_step;
    logic [HP_W-1:0] r_hp,     n_hp;
    logic [HP_W-1:0] r_cnt,    n_cnt;
    t_dir            r_dir,    n_dir;
    logic            r_dir_lvl, n_dir_lvl;
    logic            r_en,     n_en;

    logic [HP_W-1:0] w_cnt_inc;
    logic [HP_W-1:0] w_gap;
    logic [HP_W-1:0] w_dec;
    t_dir            w_sense;

    // Tick path helpers
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_gap     = r_hp - i_cfg.steady_hp;
    assign w_dec     = (w_gap < i_cfg.ramp_step) ? w_gap : i_cfg.ramp_step;
    assign w_sense   = (i_cmd_code == CMD_FWD) ? DIR_FWD : DIR_REV;

    // Next state
    always_comb begin
        n_active  = r_active;
        n_step    = r_step;
        n_hp      = r_hp;
        n_cnt     = r_cnt;
        n_dir     = r_dir;
        n_dir_lvl = r_dir_lvl;
        n_en      = r_en;
        if (i_tick && r_active) begin
            n_cnt = w_cnt_inc;
            if (w_cnt_inc >= r_hp) begin
                n_cnt  = '0;
                n_step = ~r_step;
                // falling edge ends a full pulse: ramp toward steady speed
                if (r_step && (r_hp > i_cfg.steady_hp)) begin
                    n_hp = r_hp - w_dec;
                end
            end
        end else if (i_cmd) begin
            if (i_cmd_code == CMD_STOP) begin
                n_active = 1'b0;
                n_dir    = DIR_STOP;
                n_step   = 1'b0;
                n_en     = i_cfg.stop_rel;
            end else begin
                // new or reversed direction restarts the ramp
                if (r_dir != w_sense) begin
                    n_dir_lvl = (w_sense == DIR_FWD) ? i_fwd_level : i_rev_level;
                    n_hp      = i_cfg.start_hp;
                    n_cnt     = '0;
                    n_dir     = w_sense;
                end
                n_en     = 1'b0;
                n_active = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_step    <= 1'b0;
            r_hp      <= START_HP_RST;
            r_cnt     <= '0;
            r_dir     <= DIR_STOP;
            r_dir_lvl <= 1'b0;
            r_en      <= 1'b1;
        end else begin
            r_active  <= n_active;
            r_step    <= n_step;
            r_hp      <= n_hp;
            r_cnt     <= n_cnt;
            r_dir     <= n_dir;
            r_dir_lvl <= n_dir_lvl;
            r_en      <= n_en;
        end
    end

    assign o_pins.step   = n_step;
    assign o_pins.dir    = n_dir_lvl;
    assign o_pins.enable = n_en;
    assign o_pins.active = n_active;

endmodule

// File: verif/multi_stepper_step_generator_tb.sv
// Self-checking testbench for multi_stepper_step_generator: ticks and motor commands
// in, pin levels out, each result compared against an in-bench motor predictor.
// Depends on msg_pkg and the generator RTL only.
module multi_stepper_step_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import msg_pkg::*;

    // Reverse codes: both nonzero codes other than forward mean reverse
    localparam logic [CMD_W-1:0] CMD_REV     = 2'b11;
    localparam logic [CMD_W-1:0] CMD_REV_ALT = 2'b10;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int CYCLE_LIMIT     = 1000000;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                  i_s_tuser   = OPC_TICK;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // No sender gaps while set
    bit          tx_quiet;
    int unsigned cycle_count;

    multi_stepper_step_generator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Motor pin predictor plus queue of expected pin words
    class pin_scoreboard;
        bit [HP_W-1:0]   steady_hp;
        bit [HP_W-1:0]   start_hp;
        bit [HP_W-1:0]   ramp_step;
        bit [LVL_W-1:0]  fwd_lvl;
        bit [LVL_W-1:0]  rev_lvl;
        bit              stop_rel;

        bit              running[NUM_MOTORS];
        bit              step_lvl[NUM_MOTORS];
        bit              dir_lvl[NUM_MOTORS];
        bit              enable_lvl[NUM_MOTORS];
        bit [HP_W-1:0]   half_period[NUM_MOTORS];
        bit [HP_W-1:0]   tick_cnt[NUM_MOTORS];
        t_dir            heading[NUM_MOTORS];

        logic [M_DATA_W-1:0] expected_pins[$];
        int failures, n_items, n_cmds, n_toggles, n_results, n_writes;

        function new();
            steady_hp = STEADY_HP_RST;
            start_hp  = START_HP_RST;
            ramp_step = RAMP_STEP_RST;
            fwd_lvl   = FWD_LVL_RST;
            rev_lvl   = REV_LVL_RST;
            stop_rel  = STOP_REL_RST;
            for (int m = 0; m < NUM_MOTORS; m++) begin
                running[m]     = 1'b0;
                step_lvl[m]    = 1'b0;
                dir_lvl[m]     = 1'b0;
                enable_lvl[m]  = 1'b1;
                half_period[m] = START_HP_RST;
                tick_cnt[m]    = '0;
                heading[m]     = DIR_STOP;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            n_writes++;
            case (idx)
                CFG_STEADY_HP: steady_hp = data;
                CFG_START_HP:  start_hp  = data;
                CFG_RAMP_STEP: ramp_step = data;
                CFG_FWD_LVL:   fwd_lvl   = data[LVL_W-1:0];
                CFG_REV_LVL:   rev_lvl   = data[LVL_W-1:0];
                CFG_STOP_REL:  stop_rel  = data[0];
                default: ;
            endcase
        endfunction

        // Apply one accepted item and queue the pin word it produces
        function void note_item(logic opc, logic [S_DATA_W-1:0] data);
            int                m;
            logic [CMD_W-1:0]  code;
            t_dir              want;
            bit [HP_W-1:0]     gap;
            logic [PIN_W-1:0]  st, dr, en, run;
            n_items++;
            if (opc == OPC_TICK) begin
                for (m = 0; m < NUM_MOTORS; m++) begin
                    if (running[m]) begin
                        tick_cnt[m] = tick_cnt[m] + 1'b1;
                        if (tick_cnt[m] >= half_period[m]) begin
                            tick_cnt[m] = '0;
                            step_lvl[m] = !step_lvl[m];
                            n_toggles++;
                            // ramp toward cruising speed after each falling edge
                            if (!step_lvl[m] && half_period[m] > steady_hp) begin
                                gap = half_period[m] - steady_hp;
                                half_period[m] -= (gap < ramp_step) ? gap : ramp_step;
                            end
                        end
                    end
                end
            end else begin
                n_cmds++;
                m    = int'(data[MOTOR_W-1:0]);
                code = data[MOTOR_W +: CMD_W];
                if (code == CMD_STOP) begin
                    running[m]    = 1'b0;
                    heading[m]    = DIR_STOP;
                    step_lvl[m]   = 1'b0;
                    enable_lvl[m] = stop_rel;
                end else begin
                    want = (code == CMD_FWD) ? DIR_FWD : DIR_REV;
                    // same direction again keeps the ramp where it is
                    if (heading[m] != want) begin
                        dir_lvl[m]     = (want == DIR_FWD) ? fwd_lvl[m] : rev_lvl[m];
                        half_period[m] = start_hp;
                        tick_cnt[m]    = '0;
                        heading[m]     = want;
                    end
                    enable_lvl[m] = 1'b0;
                    running[m]    = 1'b1;
                end
            end
            for (m = 0; m < PIN_W; m++) begin
                st[m]  = step_lvl[m];
                dr[m]  = dir_lvl[m];
                en[m]  = enable_lvl[m];
                run[m] = running[m];
            end
            expected_pins.push_back({run, en, dr, st});
        endfunction

        function void check_pins(logic [M_DATA_W-1:0] got);
            logic [M_DATA_W-1:0] exp_pins;
            n_results++;
            if (expected_pins.size() == 0) begin
                $error("unexpected result transfer: %h", got);
                failures++;
                return;
            end
            exp_pins = expected_pins.pop_front();
            if (got[3:0] !== exp_pins[3:0]) begin
                $error("step_pins: expected %h, got %h", exp_pins[3:0], got[3:0]);
                failures++;
            end
            if (got[7:4] !== exp_pins[7:4]) begin
                $error("dir_pins: expected %h, got %h", exp_pins[7:4], got[7:4]);
                failures++;
            end
            if (got[11:8] !== exp_pins[11:8]) begin
                $error("enable_pins: expected %h, got %h", exp_pins[11:8], got[11:8]);
                failures++;
            end
            if (got[15:12] !== exp_pins[15:12]) begin
                $error("running: expected %h, got %h", exp_pins[15:12], got[15:12]);
                failures++;
            end
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction
    endclass

    pin_scoreboard pins_sb = new();

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Observe every transfer on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                pins_sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready)
                pins_sb.note_item(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                pins_sb.check_pins(o_m_tdata);
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pins_sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: ready bursts broken by stalls, mostly short, now and then long
    initial begin
        int burst, hold, r;
        forever begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
            i_m_tready <= 1'b1;
            repeat (burst) @(posedge i_clk);
            r    = $urandom_range(0, 99);
            hold = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // One item on the input stream; tvalid stays high after the transfer
    task automatic send_item(input logic opc, input logic [MOTOR_W-1:0] motor,
                             input logic [CMD_W-1:0] code, input int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= opc;
        i_s_tdata  <= {{(S_DATA_W-MOTOR_W-CMD_W){1'b0}}, code, motor};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_tick();
        send_item(OPC_TICK, MOTOR_W'($urandom), CMD_W'($urandom), pick_gap());
    endtask

    task automatic send_cmd(input logic [MOTOR_W-1:0] motor, input logic [CMD_W-1:0] code);
        send_item(OPC_CMD, motor, code, pick_gap());
    endtask

    // Register write; caller drops i_cfg_valid after the last one
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Wait until every expected result has arrived
    task automatic drain();
        @(posedge i_clk);
        while (pins_sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return CMD_STOP;
        if (r < 6)
            return CMD_FWD;
        return (r < 8) ? CMD_REV : CMD_REV_ALT;
    endfunction

    // Register set for one phase: both extremes, pure jump, no ramp, then random
    task automatic load_settings(input int phase);
        logic [HP_W-1:0]  steady, start, ramp;
        logic [LVL_W-1:0] fwd, rev;
        logic             rel;
        case (phase)
            0: begin
                steady = '0; start = '0; ramp = '0; fwd = '0; rev = '1; rel = 1'b0;
            end
            1: begin
                steady = '1; start = '1; ramp = '1; fwd = '1; rev = '0; rel = 1'b1;
            end
            2: begin
                steady = 16'd2; start = 16'd12; ramp = '1;
                fwd = 4'b1010; rev = 4'b0101; rel = 1'b1;
            end
            3: begin
                steady = 16'd20; start = 16'd5; ramp = 16'd3;
                fwd = 4'b0110; rev = 4'b1001; rel = 1'b0;
            end
            default: begin
                steady = HP_W'($urandom_range(0, 6));
                start  = HP_W'($urandom_range(0, 24));
                ramp   = HP_W'($urandom_range(0, 4));
                fwd    = LVL_W'($urandom);
                rev    = LVL_W'($urandom);
                rel    = 1'($urandom);
            end
        endcase
        write_cfg(CFG_STEADY_HP, steady);
        write_cfg(CFG_START_HP, start);
        write_cfg(CFG_RAMP_STEP, ramp);
        // upper data bits of the narrow registers are don't-care
        write_cfg(CFG_FWD_LVL, {12'($urandom), fwd});
        write_cfg(CFG_REV_LVL, {12'($urandom), rev});
        write_cfg(CFG_STOP_REL, {15'($urandom), rel});
        if (phase == 2) begin
            write_cfg(CFG_SPARE_A, 16'($urandom));
            write_cfg(CFG_SPARE_B, 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, all codes, repeated start, reversal, stop
        tx_quiet = 1'b1;
        send_tick();
        send_cmd(2'd0, CMD_FWD);
        send_cmd(2'd1, CMD_REV);
        send_cmd(2'd2, CMD_REV_ALT);
        send_cmd(2'd3, CMD_FWD);
        repeat (3) send_tick();
        send_cmd(2'd0, CMD_FWD);
        send_tick();
        send_cmd(2'd0, CMD_REV);
        send_cmd(2'd1, CMD_FWD);
        send_cmd(2'd2, CMD_STOP);
        send_cmd(2'd3, CMD_STOP);
        send_tick();
        send_cmd(2'd2, CMD_REV_ALT);
        send_cmd(2'd3, CMD_REV);
        send_tick();
        send_cmd(2'd1, CMD_STOP);
        send_cmd(2'd1, CMD_STOP);
        send_cmd(2'd1, CMD_FWD);
        send_tick();
        i_s_tvalid <= 1'b0;

        // Random phases, each under its own register set
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            load_settings(phase);
            tx_quiet = (phase % 3 == 1);
            for (int m = 0; m < NUM_MOTORS; m++)
                send_cmd(MOTOR_W'(m), ($urandom_range(0, 1) == 1) ? CMD_FWD : CMD_REV);
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 78)
                    send_tick();
                else
                    send_cmd(MOTOR_W'($urandom), pick_code());
            end
            i_s_tvalid <= 1'b0;
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("covered %0d items (%0d commands, %0d step toggles), %0d results checked",
                 pins_sb.n_items, pins_sb.n_cmds, pins_sb.n_toggles, pins_sb.n_results);
        $display("%0d register writes over %0d register sets, %0d failures",
                 pins_sb.n_writes, NUM_PHASES, pins_sb.failures);
        if (pins_sb.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
rtl/msg_pkg.sv
rtl/msg_motor_lane.sv
rtl/multi_stepper_step_generator.sv
verif/multi_stepper_step_generator_tb.sv
